>>> hdl/imhdk_pkg.sv
// Shared types and constants of the indexed min-heap with decrease-key.
// Holds command, status and sequencer codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package imhdk_pkg;

  localparam logic [63:0] INF_KEY = 64'd501073736822;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_RELAX = 2'd2
  } command_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_REFUSED = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT,
    S_POP_A,
    S_POP_B,
    S_POP_C,
    S_POP_D,
    S_DN_L,
    S_DN_R,
    S_DN_K,
    S_DN_P,
    S_DN_C,
    S_DN_S,
    S_RX_A,
    S_RX_B,
    S_UP_P,
    S_UP_E,
    S_UP_K,
    S_UP_S,
    S_EMIT
  } state_e;

endpackage

`default_nettype wire

>>> hdl/indexed_min_heap_decrease_key.sv
// Indexed binary min-heap with decrease-key: heap, position and key tables,
// one shared key comparator and the command sequencer. Uses imhdk_pkg.
//
// One command is worked at a time; in_stall_o stays high until its result
// is loaded into the output register, which a stalled consumer may hold
// while the next command is taken. How long each command takes is set by
// the single read port of each table (registered read data) and the one
// key comparator: init walks every entry; pop works through each heap
// level the moved entry sinks; relax through each level the entry rises;
// pop on empty, out-of-range relax and the unused command go straight to
// the result. The position table reads as all absent until the first
// init, so no clearing pass runs after reset.
`timescale 1ns / 1ps
`default_nettype none

module indexed_min_heap_decrease_key #(
  parameter int CAPACITY = 1024,
  parameter int KEY_BITS = 40
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [1:0]                       command_i,
  input  wire  [$clog2(CAPACITY)-1:0]      entry_i,
  input  wire  [KEY_BITS-1:0]              new_key_i,
  input  wire  [$clog2(CAPACITY+1)-1:0]    fill_count_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [$clog2(CAPACITY)-1:0]      popped_entry_o,
  output logic [KEY_BITS-1:0]              popped_key_o,
  output logic [1:0]                       status_o,
  output logic [$clog2(CAPACITY+1)-1:0]    remaining_o
);

  localparam int ENTRY_W = $clog2(CAPACITY);
  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam logic [COUNT_W-1:0] CAP_C    = COUNT_W'(CAPACITY);
  localparam logic [ENTRY_W-1:0] LAST_IDX = ENTRY_W'(CAPACITY - 1);
  localparam logic [63:0]        KEY_MAX  = {64{1'b1}} >> (64 - KEY_BITS);
  localparam logic [KEY_BITS-1:0] INF_C   =
    (imhdk_pkg::INF_KEY > KEY_MAX) ? {KEY_BITS{1'b1}} : KEY_BITS'(imhdk_pkg::INF_KEY);

  // Tables
  logic [ENTRY_W-1:0]  heap_mem [CAPACITY];
  logic [COUNT_W-1:0]  pos_mem  [CAPACITY];
  logic [KEY_BITS-1:0] key_mem  [CAPACITY];

  logic                heap_we;
  logic [ENTRY_W-1:0]  heap_waddr, heap_raddr, heap_wdata, heap_rdata_q;
  logic                pos_we;
  logic [ENTRY_W-1:0]  pos_waddr, pos_raddr;
  logic [COUNT_W-1:0]  pos_wdata, pos_rdata_q;
  logic                key_we;
  logic [ENTRY_W-1:0]  key_waddr, key_raddr;
  logic [KEY_BITS-1:0] key_wdata, key_rdata_q;

  always_ff @(posedge clk_i) begin
    if (heap_we) begin
      heap_mem[heap_waddr] <= heap_wdata;
    end
    heap_rdata_q <= heap_mem[heap_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    pos_rdata_q <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    key_rdata_q <= key_mem[key_raddr];
  end

  // Shared key comparator
  logic [KEY_BITS-1:0] cmp_a, cmp_b;
  logic                cmp_lt;
  assign cmp_lt = cmp_a < cmp_b;

  // Sequencer state
  imhdk_pkg::state_e   state_q, state_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic                init_done_q, init_done_d;
  logic                out_valid_q, out_valid_d;
  logic [COUNT_W-1:0]  lim_q, lim_d;
  logic [ENTRY_W-1:0]  idx_q, idx_d;
  logic [COUNT_W-1:0]  node_q, node_d;
  logic [COUNT_W-1:0]  pick_q, pick_d;
  logic                have_right_q, have_right_d;
  logic [ENTRY_W-1:0]  e_n_q, e_n_d, e_a_q, e_a_d, e_b_q, e_b_d;
  logic [KEY_BITS-1:0] k_n_q, k_n_d, k_a_q, k_a_d;
  logic [ENTRY_W-1:0]  ent_q, ent_d;
  logic [KEY_BITS-1:0] nkey_q, nkey_d;
  logic [ENTRY_W-1:0]  res_entry_q, res_entry_d;
  logic [KEY_BITS-1:0] res_key_q, res_key_d;
  imhdk_pkg::status_e  res_status_q, res_status_d;
  logic [ENTRY_W-1:0]  popped_entry_q, popped_entry_d;
  logic [KEY_BITS-1:0] popped_key_q, popped_key_d;
  imhdk_pkg::status_e  status_q, status_d;
  logic [COUNT_W-1:0]  remaining_q, remaining_d;

  logic                in_take, emit;
  logic [COUNT_W:0]    left_w, right_w;
  logic [COUNT_W-1:0]  count_m1, node_m1, parent, parent_m1, pick_m1, slot;
  logic [COUNT_W-1:0]  idx_ext, fill_sat;
  logic [COUNT_W-1:0]  left_m1;

  assign in_stall_o = (state_q != imhdk_pkg::S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign emit       = (state_q == imhdk_pkg::S_EMIT) && (!out_valid_q || !out_stall_i);

  assign left_w    = {node_q, 1'b0};
  assign right_w   = left_w + 1'b1;
  assign left_m1   = COUNT_W'(left_w - 1'b1);
  assign count_m1  = count_q - 1'b1;
  assign node_m1   = node_q - 1'b1;
  assign parent    = node_q >> 1;
  assign parent_m1 = parent - 1'b1;
  assign pick_m1   = pick_q - 1'b1;
  assign idx_ext   = COUNT_W'(idx_q);
  assign fill_sat  = (fill_count_i > CAP_C) ? CAP_C : fill_count_i;
  assign slot      = init_done_q ? pos_rdata_q : '0;

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    init_done_d    = init_done_q;
    lim_d          = lim_q;
    idx_d          = idx_q;
    node_d         = node_q;
    pick_d         = pick_q;
    have_right_d   = have_right_q;
    e_n_d          = e_n_q;
    e_a_d          = e_a_q;
    e_b_d          = e_b_q;
    k_n_d          = k_n_q;
    k_a_d          = k_a_q;
    ent_d          = ent_q;
    nkey_d         = nkey_q;
    res_entry_d    = res_entry_q;
    res_key_d      = res_key_q;
    res_status_d   = res_status_q;
    popped_entry_d = popped_entry_q;
    popped_key_d   = popped_key_q;
    status_d       = status_q;
    remaining_d    = remaining_q;
    out_valid_d    = out_valid_q && out_stall_i;
    heap_we        = 1'b0;
    heap_waddr     = '0;
    heap_wdata     = '0;
    heap_raddr     = '0;
    pos_we         = 1'b0;
    pos_waddr      = '0;
    pos_wdata      = '0;
    pos_raddr      = '0;
    key_we         = 1'b0;
    key_waddr      = '0;
    key_wdata      = '0;
    key_raddr      = '0;
    cmp_a          = '0;
    cmp_b          = '0;

    case (state_q)
      imhdk_pkg::S_IDLE: begin
        if (in_take) begin
          ent_d        = entry_i;
          nkey_d       = new_key_i;
          res_entry_d  = '0;
          res_key_d    = '0;
          res_status_d = imhdk_pkg::ST_DONE;
          case (imhdk_pkg::command_e'(command_i))
            imhdk_pkg::CMD_INIT: begin
              lim_d   = fill_sat;
              idx_d   = '0;
              state_d = imhdk_pkg::S_INIT;
            end
            imhdk_pkg::CMD_POP: begin
              if (count_q == '0) begin
                res_status_d = imhdk_pkg::ST_EMPTY;
                state_d      = imhdk_pkg::S_EMIT;
              end else begin
                state_d = imhdk_pkg::S_POP_A;
              end
            end
            imhdk_pkg::CMD_RELAX: begin
              if (COUNT_W'(entry_i) >= CAP_C) begin
                res_status_d = imhdk_pkg::ST_RANGE;
                state_d      = imhdk_pkg::S_EMIT;
              end else begin
                state_d = imhdk_pkg::S_RX_A;
              end
            end
            default: begin
              res_status_d = imhdk_pkg::ST_REFUSED;
              state_d      = imhdk_pkg::S_EMIT;
            end
          endcase
        end
      end

      imhdk_pkg::S_INIT: begin
        key_we     = 1'b1;
        key_waddr  = idx_q;
        key_wdata  = INF_C;
        heap_we    = (idx_ext < lim_q);
        heap_waddr = idx_q;
        heap_wdata = idx_q;
        pos_we     = 1'b1;
        pos_waddr  = idx_q;
        pos_wdata  = (idx_ext < lim_q) ? idx_ext + 1'b1 : '0;
        if (idx_q == LAST_IDX) begin
          count_d     = lim_q;
          init_done_d = 1'b1;
          state_d     = imhdk_pkg::S_EMIT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      imhdk_pkg::S_POP_A: begin
        heap_raddr = '0;
        state_d    = imhdk_pkg::S_POP_B;
      end

      imhdk_pkg::S_POP_B: begin
        e_a_d      = heap_rdata_q;
        key_raddr  = heap_rdata_q;
        heap_raddr = count_m1[ENTRY_W-1:0];
        state_d    = imhdk_pkg::S_POP_C;
      end

      imhdk_pkg::S_POP_C: begin
        res_entry_d = e_a_q;
        res_key_d   = key_rdata_q;
        e_n_d       = heap_rdata_q;
        key_raddr   = heap_rdata_q;
        pos_we      = 1'b1;
        pos_waddr   = e_a_q;
        pos_wdata   = '0;
        count_d     = count_m1;
        state_d     = (count_m1 == '0) ? imhdk_pkg::S_EMIT : imhdk_pkg::S_POP_D;
      end

      imhdk_pkg::S_POP_D: begin
        k_n_d      = key_rdata_q;
        heap_we    = 1'b1;
        heap_waddr = '0;
        heap_wdata = e_n_q;
        pos_we     = 1'b1;
        pos_waddr  = e_n_q;
        pos_wdata  = COUNT_W'(1);
        node_d     = COUNT_W'(1);
        state_d    = imhdk_pkg::S_DN_L;
      end

      imhdk_pkg::S_DN_L: begin
        if (left_w > {1'b0, count_q}) begin
          state_d = imhdk_pkg::S_EMIT;
        end else begin
          heap_raddr = left_m1[ENTRY_W-1:0];
          state_d    = imhdk_pkg::S_DN_R;
        end
      end

      imhdk_pkg::S_DN_R: begin
        e_a_d        = heap_rdata_q;
        key_raddr    = heap_rdata_q;
        heap_raddr   = left_w[ENTRY_W-1:0];
        have_right_d = (right_w <= {1'b0, count_q});
        pick_d       = left_w[COUNT_W-1:0];
        state_d      = imhdk_pkg::S_DN_K;
      end

      imhdk_pkg::S_DN_K: begin
        k_a_d     = key_rdata_q;
        e_b_d     = heap_rdata_q;
        key_raddr = heap_rdata_q;
        state_d   = imhdk_pkg::S_DN_P;
      end

      imhdk_pkg::S_DN_P: begin
        cmp_a = key_rdata_q;
        cmp_b = k_a_q;
        if (have_right_q && cmp_lt) begin
          pick_d = right_w[COUNT_W-1:0];
          e_a_d  = e_b_q;
          k_a_d  = key_rdata_q;
        end
        state_d = imhdk_pkg::S_DN_C;
      end

      imhdk_pkg::S_DN_C: begin
        cmp_a = k_a_q;
        cmp_b = k_n_q;
        if (cmp_lt) begin
          heap_we    = 1'b1;
          heap_waddr = node_m1[ENTRY_W-1:0];
          heap_wdata = e_a_q;
          pos_we     = 1'b1;
          pos_waddr  = e_a_q;
          pos_wdata  = node_q;
          state_d    = imhdk_pkg::S_DN_S;
        end else begin
          state_d = imhdk_pkg::S_EMIT;
        end
      end

      imhdk_pkg::S_DN_S: begin
        heap_we    = 1'b1;
        heap_waddr = pick_m1[ENTRY_W-1:0];
        heap_wdata = e_n_q;
        pos_we     = 1'b1;
        pos_waddr  = e_n_q;
        pos_wdata  = pick_q;
        node_d     = pick_q;
        state_d    = imhdk_pkg::S_DN_L;
      end

      imhdk_pkg::S_RX_A: begin
        pos_raddr = ent_q;
        key_raddr = ent_q;
        state_d   = imhdk_pkg::S_RX_B;
      end

      imhdk_pkg::S_RX_B: begin
        cmp_a = nkey_q;
        cmp_b = key_rdata_q;
        if (slot == '0 || !cmp_lt) begin
          res_status_d = imhdk_pkg::ST_REFUSED;
          state_d      = imhdk_pkg::S_EMIT;
        end else begin
          key_we    = 1'b1;
          key_waddr = ent_q;
          key_wdata = nkey_q;
          node_d    = slot;
          e_n_d     = ent_q;
          k_n_d     = nkey_q;
          state_d   = imhdk_pkg::S_UP_P;
        end
      end

      imhdk_pkg::S_UP_P: begin
        if (node_q <= COUNT_W'(1)) begin
          state_d = imhdk_pkg::S_EMIT;
        end else begin
          heap_raddr = parent_m1[ENTRY_W-1:0];
          state_d    = imhdk_pkg::S_UP_E;
        end
      end

      imhdk_pkg::S_UP_E: begin
        e_a_d     = heap_rdata_q;
        key_raddr = heap_rdata_q;
        state_d   = imhdk_pkg::S_UP_K;
      end

      imhdk_pkg::S_UP_K: begin
        cmp_a = k_n_q;
        cmp_b = key_rdata_q;
        if (cmp_lt) begin
          heap_we    = 1'b1;
          heap_waddr = node_m1[ENTRY_W-1:0];
          heap_wdata = e_a_q;
          pos_we     = 1'b1;
          pos_waddr  = e_a_q;
          pos_wdata  = node_q;
          state_d    = imhdk_pkg::S_UP_S;
        end else begin
          state_d = imhdk_pkg::S_EMIT;
        end
      end

      imhdk_pkg::S_UP_S: begin
        heap_we    = 1'b1;
        heap_waddr = parent_m1[ENTRY_W-1:0];
        heap_wdata = e_n_q;
        pos_we     = 1'b1;
        pos_waddr  = e_n_q;
        pos_wdata  = parent;
        node_d     = parent;
        state_d    = imhdk_pkg::S_UP_P;
      end

      imhdk_pkg::S_EMIT: begin
        if (emit) begin
          popped_entry_d = res_entry_q;
          popped_key_d   = res_key_q;
          status_d       = res_status_q;
          remaining_d    = count_q;
          out_valid_d    = 1'b1;
          state_d        = imhdk_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = imhdk_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= imhdk_pkg::S_IDLE;
      count_q     <= '0;
      init_done_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      init_done_q <= init_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q          <= lim_d;
    idx_q          <= idx_d;
    node_q         <= node_d;
    pick_q         <= pick_d;
    have_right_q   <= have_right_d;
    e_n_q          <= e_n_d;
    e_a_q          <= e_a_d;
    e_b_q          <= e_b_d;
    k_n_q          <= k_n_d;
    k_a_q          <= k_a_d;
    ent_q          <= ent_d;
    nkey_q         <= nkey_d;
    res_entry_q    <= res_entry_d;
    res_key_q      <= res_key_d;
    res_status_q   <= res_status_d;
    popped_entry_q <= popped_entry_d;
    popped_key_q   <= popped_key_d;
    status_q       <= status_d;
    remaining_q    <= remaining_d;
  end

  assign out_valid_o    = out_valid_q;
  assign popped_entry_o = popped_entry_q;
  assign popped_key_o   = popped_key_q;
  assign status_o       = status_q;
  assign remaining_o    = remaining_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C)
    else $error("queued count above capacity");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_stall_o)
    else $error("item taken while another is in work");

  a_emit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_o && !in_stall_o)
    else $error("result not loaded on finish");

  a_count_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != imhdk_pkg::S_INIT && state_q != imhdk_pkg::S_POP_C) |=> $stable(count_q))
    else $error("queued count changed outside init or pop");

  a_sink_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == imhdk_pkg::S_DN_L) |-> (node_q != '0 && node_q <= count_q))
    else $error("sift-down node outside the heap");

endmodule

`default_nettype wire
